@@ sv/sle_pkg.sv @@
// Package for the sequential list engine.
// Holds list sizing constants, operation and status codes, the sequencer
// states and the structs that pass between the sequencer, the RAM and the top level.
package sle_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_INSERT     = 3'd4,
        OP_ERASE      = 3'd5,
        OP_FIND       = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_FIND,
        S_DRAIN,
        S_PUT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } ram_req_t;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [5:0]       found_index;
        logic [CNT_W-1:0] count_now;
    } result_t;

endpackage

@@ sv/sle_ram.sv @@
// Element store for the list engine: one write port, one registered read port.
// Depends on sle_pkg for sizing and the request struct.
module sle_ram (
    input  logic                          clk,
    input  sle_pkg::ram_req_t             req,
    output logic [sle_pkg::DATA_W-1:0]    rd_data
);

    logic [sle_pkg::DATA_W-1:0] mem [sle_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

@@ sv/sle_seq.sv @@
// Sequencer of the list engine: decodes a request, walks the element RAM one
// slot per cycle to shift or search, and keeps the element count.
// Depends on sle_pkg.
module sle_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [2:0]                    op,
    input  logic [6:0]                    position,
    input  logic [sle_pkg::DATA_W-1:0]    value,
    output logic                          idle,
    output sle_pkg::ram_req_t             ram_req,
    input  logic [sle_pkg::DATA_W-1:0]    rd_data,
    output logic                          res_valid,
    output sle_pkg::result_t              res,
    input  logic                          res_take
);

    sle_pkg::state_t                 state_reg, state_next;
    logic [sle_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [sle_pkg::ADDR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [sle_pkg::ADDR_W-1:0]      stop_reg, stop_next;
    logic [sle_pkg::ADDR_W-1:0]      put_addr_reg, put_addr_next;
    logic [sle_pkg::ADDR_W-1:0]      pend_addr_reg, pend_addr_next;
    logic                            pend_reg, pend_next;
    logic                            more_reg, more_next;
    logic                            up_reg, up_next;
    logic [sle_pkg::DATA_W-1:0]      val_reg, val_next;
    sle_pkg::status_t                status_reg, status_next;
    logic                            found_reg, found_next;
    logic [5:0]                      fidx_reg, fidx_next;

    logic [sle_pkg::CNT_W-1:0]       ins_pos;
    logic [sle_pkg::CNT_W-1:0]       del_pos;
    logic                            is_ins;
    logic                            is_del;
    logic                            is_find;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sle_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            more_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            more_reg  <= more_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg    <= rd_ptr_next;
        stop_reg      <= stop_next;
        put_addr_reg  <= put_addr_next;
        pend_addr_reg <= pend_addr_next;
        up_reg        <= up_next;
        val_reg       <= val_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        fidx_reg      <= fidx_next;
    end

    // Every defined op maps onto insert, erase or find; pop back is an erase of the last slot.
    always_comb
    begin
        is_ins  = 1'b0;
        is_del  = 1'b0;
        is_find = 1'b0;
        ins_pos = position;
        del_pos = position;
        unique case (op)
            sle_pkg::OP_PUSH_BACK:
            begin
                is_ins  = 1'b1;
                ins_pos = count_reg;
            end
            sle_pkg::OP_PUSH_FRONT:
            begin
                is_ins  = 1'b1;
                ins_pos = '0;
            end
            sle_pkg::OP_INSERT:
            begin
                is_ins = 1'b1;
            end
            sle_pkg::OP_POP_BACK:
            begin
                is_del  = 1'b1;
                del_pos = count_reg - 1'b1;
            end
            sle_pkg::OP_POP_FRONT:
            begin
                is_del  = 1'b1;
                del_pos = '0;
            end
            sle_pkg::OP_ERASE:
            begin
                is_del = 1'b1;
            end
            sle_pkg::OP_FIND:
            begin
                is_find = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        stop_next      = stop_reg;
        put_addr_next  = put_addr_reg;
        pend_addr_next = pend_addr_reg;
        pend_next      = pend_reg;
        more_next      = more_reg;
        up_next        = up_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        fidx_next      = fidx_reg;

        ram_req         = '0;
        ram_req.rd_addr = rd_ptr_reg;
        ram_req.wr_addr = up_reg ? sle_pkg::ADDR_W'(pend_addr_reg + 1'b1)
                                 : sle_pkg::ADDR_W'(pend_addr_reg - 1'b1);
        ram_req.wr_data = rd_data;

        idle      = 1'b0;
        res_valid = 1'b0;

        unique case (state_reg)
            sle_pkg::S_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    val_next    = value;
                    status_next = sle_pkg::ST_OK;
                    found_next  = 1'b0;
                    fidx_next   = '0;
                    pend_next   = 1'b0;
                    state_next  = sle_pkg::S_DONE;
                    if (is_ins)
                    begin
                        up_next       = 1'b1;
                        put_addr_next = sle_pkg::ADDR_W'(ins_pos);
                        rd_ptr_next   = sle_pkg::ADDR_W'(count_reg - 1'b1);
                        stop_next     = sle_pkg::ADDR_W'(ins_pos);
                        if (ins_pos > count_reg)
                        begin
                            status_next = sle_pkg::ST_BADPOS;
                        end
                        else if (count_reg >= sle_pkg::CNT_W'(sle_pkg::CAPACITY))
                        begin
                            status_next = sle_pkg::ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            state_next = (ins_pos == count_reg) ? sle_pkg::S_PUT
                                                                : sle_pkg::S_SHIFT_UP;
                        end
                    end
                    else if (is_del)
                    begin
                        up_next     = 1'b0;
                        rd_ptr_next = sle_pkg::ADDR_W'(del_pos + 1'b1);
                        stop_next   = sle_pkg::ADDR_W'(count_reg - 1'b1);
                        if (count_reg == '0)
                        begin
                            status_next = sle_pkg::ST_EMPTY;
                        end
                        else if (del_pos >= count_reg)
                        begin
                            status_next = sle_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            if (del_pos != count_reg - 1'b1)
                            begin
                                state_next = sle_pkg::S_SHIFT_DN;
                            end
                        end
                    end
                    else if (is_find)
                    begin
                        rd_ptr_next = '0;
                        stop_next   = sle_pkg::ADDR_W'(count_reg - 1'b1);
                        more_next   = 1'b1;
                        if (count_reg != '0)
                        begin
                            state_next = sle_pkg::S_FIND;
                        end
                    end
                end
            end

            // Read slot i while writing the element read the cycle before into its neighbouring slot.
            sle_pkg::S_SHIFT_UP,
            sle_pkg::S_SHIFT_DN:
            begin
                ram_req.rd_en  = 1'b1;
                ram_req.wr_en  = pend_reg;
                pend_next      = 1'b1;
                pend_addr_next = rd_ptr_reg;
                if (rd_ptr_reg == stop_reg)
                begin
                    state_next = sle_pkg::S_DRAIN;
                end
                else if (up_reg)
                begin
                    rd_ptr_next = rd_ptr_reg - 1'b1;
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
            end

            sle_pkg::S_DRAIN:
            begin
                ram_req.wr_en = 1'b1;
                pend_next     = 1'b0;
                state_next    = up_reg ? sle_pkg::S_PUT : sle_pkg::S_DONE;
            end

            sle_pkg::S_PUT:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = put_addr_reg;
                ram_req.wr_data = val_reg;
                state_next      = sle_pkg::S_DONE;
            end

            // Compare the slot read last cycle; stop at the first hit.
            sle_pkg::S_FIND:
            begin
                if (pend_reg && rd_data == val_reg)
                begin
                    found_next = 1'b1;
                    fidx_next  = 6'(pend_addr_reg);
                    pend_next  = 1'b0;
                    state_next = sle_pkg::S_DONE;
                end
                else if (more_reg)
                begin
                    ram_req.rd_en  = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg;
                    if (rd_ptr_reg == stop_reg)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = sle_pkg::S_DONE;
                end
            end

            sle_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = sle_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sle_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status      = status_reg;
        res.found       = found_reg;
        res.found_index = fidx_reg;
        res.count_now   = count_reg;
    end

endmodule

@@ sv/sequential_list_engine_top.sv @@
// Sequential list engine: an ordered list of up to 64 signed 32-bit values with push/pop at
// either end, insert, erase and find; one result item per request item. Pop back, an unused op
// and any request that fails its check go straight to the result; push back or an insert at
// the end only write the value; insert and push front shift the tail up and then write the
// value; erase and pop front shift the tail down unless they remove the last element; find
// reads from slot 0 and stops at the first hit. The RAM walk moves one element per cycle
// through one read and one write port, and find compares one slot per cycle. The next item
// is taken in the cycle after the result moves into the output register. in_stall is high
// while an item is being worked and while a finished result cannot move into the output
// register; a result waiting there does not block the next item. Depends on sle_pkg,
// sle_ram, sle_seq.
module sequential_list_engine_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         op,
    input  logic [6:0]         position,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic               found,
    output logic [5:0]         found_index,
    output logic [6:0]         count_now
);

    sle_pkg::ram_req_t          ram_req;
    logic [sle_pkg::DATA_W-1:0] rd_data;
    logic                       idle;
    logic                       res_valid;
    logic                       res_take;
    sle_pkg::result_t           res;
    sle_pkg::result_t           out_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       in_accept;

    assign in_stall  = !idle;
    assign in_accept = in_valid && !in_stall;
    assign res_take  = res_valid && (!out_valid_reg || !out_stall);

    sle_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    sle_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .op        (op),
        .position  (position),
        .value     (sle_pkg::DATA_W'(value)),
        .idle      (idle),
        .ram_req   (ram_req),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign found       = out_reg.found;
    assign found_index = out_reg.found_index;
    assign count_now   = out_reg.count_now;

    // An accepted item keeps the input side busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input not stalled after accept");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count_now <= 7'(sle_pkg::CAPACITY)))
        else $error("count above capacity");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (status == sle_pkg::ST_OK))
        else $error("found with non-ok status");

    a_absent_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (found_index == 6'd0))
        else $error("index set without a hit");

endmodule

@@ verif/tb_sequential_list_engine_top.sv @@
// Self-checking testbench for sequential_list_engine_top: list operations are
// predicted by a behavioral list kept in the bench, and results are compared in order.
// Depends on sle_pkg and the engine RTL.
`timescale 1ns / 100ps

module tb_sequential_list_engine_top;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [31:0] MIN_INT = 32'h8000_0000;
    localparam logic [31:0] MAX_INT = 32'h7fff_ffff;
    localparam logic [31:0] NEG_ONE = 32'hffff_ffff;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct {
        sle_pkg::status_t status;
        logic             found;
        logic [5:0]       found_index;
        logic [6:0]       count_now;
    } list_outcome_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         op = '0;
    logic [6:0]         position = '0;
    logic signed [31:0] value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic               found;
    logic [5:0]         found_index;
    logic [6:0]         count_now;

    // behavioral copy of the list
    logic [31:0]   list_slots [sle_pkg::CAPACITY];
    int            list_len = 0;
    list_outcome_t pending_outcomes [$];
    list_outcome_t oldest;

    int mismatch_count = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_left = 0;

    sequential_list_engine_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .count_now   (count_now)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_outcomes.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
            rx_hold_left--;
        else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct)
            rx_hold_left = $urandom_range(1, 9);
        out_stall <= (rx_hold_left > 0);
    end

    task automatic report_mismatch(input string what, input int got, input int want_v);
        $display("mismatch in result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want_v);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("unexpected item, nothing pending", status, 0);
            else
            begin
                oldest = pending_outcomes.pop_front();
                if (status !== oldest.status)
                    report_mismatch("status", status, oldest.status);
                if (found !== oldest.found)
                    report_mismatch("found", found, oldest.found);
                if (found_index !== oldest.found_index)
                    report_mismatch("found_index", found_index, oldest.found_index);
                if (count_now !== oldest.count_now)
                    report_mismatch("count_now", count_now, oldest.count_now);
            end
            results_seen++;
        end
    end

    // applies one request to the bench list and returns what the engine should answer
    function automatic list_outcome_t apply_request(input logic [2:0] code,
                                                    input logic [6:0] pos,
                                                    input logic [31:0] val);
        list_outcome_t r;
        int i;
        r.status = sle_pkg::ST_OK;
        r.found = 1'b0;
        r.found_index = '0;
        case (code)
            sle_pkg::OP_PUSH_BACK:
                if (list_len >= sle_pkg::CAPACITY)
                    r.status = sle_pkg::ST_FULL;
                else
                begin
                    list_slots[6'(list_len)] = val;
                    list_len++;
                end
            sle_pkg::OP_POP_BACK:
                if (list_len == 0)
                    r.status = sle_pkg::ST_EMPTY;
                else
                    list_len--;
            sle_pkg::OP_PUSH_FRONT:
                if (list_len >= sle_pkg::CAPACITY)
                    r.status = sle_pkg::ST_FULL;
                else
                begin
                    for (i = list_len; i > 0; i--)
                        list_slots[6'(i)] = list_slots[6'(i-1)];
                    list_slots[0] = val;
                    list_len++;
                end
            sle_pkg::OP_POP_FRONT:
                if (list_len == 0)
                    r.status = sle_pkg::ST_EMPTY;
                else
                begin
                    for (i = 0; i + 1 < list_len; i++)
                        list_slots[6'(i)] = list_slots[6'(i+1)];
                    list_len--;
                end
            sle_pkg::OP_INSERT:
                // range check wins over the full check
                if (pos > list_len)
                    r.status = sle_pkg::ST_BADPOS;
                else if (list_len >= sle_pkg::CAPACITY)
                    r.status = sle_pkg::ST_FULL;
                else
                begin
                    for (i = list_len; i > pos; i--)
                        list_slots[6'(i)] = list_slots[6'(i-1)];
                    list_slots[6'(pos)] = val;
                    list_len++;
                end
            sle_pkg::OP_ERASE:
                if (list_len == 0)
                    r.status = sle_pkg::ST_EMPTY;
                else if (pos >= list_len)
                    r.status = sle_pkg::ST_BADPOS;
                else
                begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_slots[6'(i)] = list_slots[6'(i+1)];
                    list_len--;
                end
            sle_pkg::OP_FIND:
                for (i = 0; i < list_len && !r.found; i++)
                    if (list_slots[6'(i)] == val)
                    begin
                        r.found = 1'b1;
                        r.found_index = i[5:0];
                    end
            default:
                ;
        endcase
        r.count_now = list_len[6:0];
        return r;
    endfunction

    // called at a rising edge; returns at the edge that took the item or after a gap
    task automatic send_item(input logic [2:0] code, input logic [6:0] pos,
                             input logic [31:0] val);
        int gap;
        op <= code;
        position <= pos;
        value <= val;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_outcomes.push_back(apply_request(code, pos, val));
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_outcomes.size() != 0);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = MIN_INT;
            1: v = MAX_INT;
            2: v = NEG_ONE;
            3, 4: v = $urandom;
            default: v = $urandom_range(0, 24);
        endcase
        return v;
    endfunction

    task automatic test_empty_list;
        send_item(sle_pkg::OP_FIND, 7'd0, 32'd0);
        send_item(sle_pkg::OP_POP_BACK, 7'd0, 32'd0);
        send_item(sle_pkg::OP_POP_FRONT, 7'd0, 32'd0);
        send_item(sle_pkg::OP_ERASE, 7'd0, 32'd0);
        send_item(sle_pkg::OP_INSERT, 7'd1, 32'd3);
        send_item(OP_UNUSED, 7'h7f, NEG_ONE);
        send_item(sle_pkg::OP_INSERT, 7'd0, MIN_INT);
    endtask

    task automatic test_edge_values;
        send_item(sle_pkg::OP_PUSH_BACK, 7'd0, MAX_INT);
        send_item(sle_pkg::OP_PUSH_FRONT, 7'h7f, NEG_ONE);
        send_item(sle_pkg::OP_PUSH_BACK, 7'd0, NEG_ONE);
        // duplicate value: lowest slot must win
        send_item(sle_pkg::OP_FIND, 7'd0, NEG_ONE);
        send_item(sle_pkg::OP_FIND, 7'd0, MAX_INT);
        send_item(sle_pkg::OP_FIND, 7'd0, 32'd0);
        send_item(sle_pkg::OP_INSERT, list_len[6:0], 32'd0);
        send_item(sle_pkg::OP_INSERT, 7'd2, 32'd5);
        send_item(sle_pkg::OP_ERASE, list_len[6:0], 32'd0);
        send_item(sle_pkg::OP_ERASE, 7'h7f, 32'd0);
        send_item(sle_pkg::OP_INSERT, 7'h7f, 32'd9);
        send_item(sle_pkg::OP_ERASE, 7'd1, 32'd0);
        send_item(sle_pkg::OP_POP_FRONT, 7'd0, 32'd0);
        send_item(sle_pkg::OP_POP_BACK, 7'd0, 32'd0);
        send_item(sle_pkg::OP_PUSH_BACK, 7'd0, 32'h5555_5555);
    endtask

    task automatic test_full_list;
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        while (list_len < sle_pkg::CAPACITY - 1)
            send_item(sle_pkg::OP_PUSH_BACK, 7'd0, $urandom_range(0, 1000));
        // marker in the last slot so find reports index 63
        send_item(sle_pkg::OP_PUSH_BACK, 7'd0, 32'hffff_fffb);
        send_item(sle_pkg::OP_FIND, 7'd0, 32'hffff_fffb);
        send_item(sle_pkg::OP_PUSH_BACK, 7'd0, 32'd1);
        send_item(sle_pkg::OP_PUSH_FRONT, 7'd0, 32'd1);
        send_item(sle_pkg::OP_INSERT, 7'd64, 32'd1);
        send_item(sle_pkg::OP_INSERT, 7'd0, 32'd1);
        send_item(sle_pkg::OP_INSERT, 7'd65, 32'd1);
        send_item(sle_pkg::OP_INSERT, 7'h7f, 32'd1);
        send_item(sle_pkg::OP_ERASE, 7'd64, 32'd0);
        send_item(sle_pkg::OP_ERASE, 7'd63, 32'd0);
        send_item(sle_pkg::OP_FIND, 7'd0, 32'hffff_fffb);
        send_item(sle_pkg::OP_POP_FRONT, 7'd0, 32'd0);
        send_item(sle_pkg::OP_PUSH_FRONT, 7'd0, MAX_INT);
        send_item(sle_pkg::OP_INSERT, 7'd63, MIN_INT);
        wait_for_results();
    endtask

    // grow_pct steers the list length up or down so both ends get reached
    task automatic random_requests(input int items, input int grow_pct);
        int n;
        int pick;
        logic [2:0] code;
        logic [6:0] pos;
        logic [31:0] val;
        for (n = 0; n < items; n++)
        begin
            pick = $urandom_range(0, 99);
            pos = '0;
            val = pick_value();
            if (pick < 5)
            begin
                code = 3'($urandom_range(0, 7));
                pos = 7'($urandom_range(0, 127));
            end
            else if (pick < 5 + grow_pct)
            begin
                case ($urandom_range(0, 2))
                    0: code = sle_pkg::OP_PUSH_BACK;
                    1: code = sle_pkg::OP_PUSH_FRONT;
                    default:
                    begin
                        code = sle_pkg::OP_INSERT;
                        pos = 7'($urandom_range(0, list_len));
                    end
                endcase
            end
            else if (pick < 85)
            begin
                case ($urandom_range(0, 2))
                    0: code = sle_pkg::OP_POP_BACK;
                    1: code = sle_pkg::OP_POP_FRONT;
                    default:
                    begin
                        code = sle_pkg::OP_ERASE;
                        if (list_len > 0)
                            pos = 7'($urandom_range(0, list_len - 1));
                    end
                endcase
            end
            else
            begin
                code = sle_pkg::OP_FIND;
                if (list_len > 0 && $urandom_range(0, 9) < 7)
                    val = list_slots[6'($urandom_range(0, list_len - 1))];
            end
            send_item(code, pos, val);
        end
    endtask

    task automatic test_random_mix;
        int phase;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase % 3)
                0:
                begin
                    tx_idle_pct = 25;
                    rx_idle_pct = 25;
                end
                1:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 40;
                end
                default:
                begin
                    tx_idle_pct = 40;
                    rx_idle_pct = 0;
                end
            endcase
            random_requests(250, (phase % 2 == 0) ? 55 : 20);
        end
        wait_for_results();
    endtask

    task automatic test_steady_stream;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_requests(150, 55);
        random_requests(150, 20);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_empty_list();
        test_edge_values();
        test_full_list();
        test_random_mix();
        test_steady_stream();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
